// ===== rtl/gcov_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcov_pkg
// widths, constants and stage payload types of the 3d covariance pipeline
// ----------------------------------------------------------------------------
package gcov_pkg;

    localparam int SCALE_W  = 24;
    localparam int QUAT_W   = 16;
    localparam int MOD_W    = 16;
    localparam int EPROD_W  = SCALE_W + MOD_W;
    localparam int E_FRAC   = 12;
    localparam int E_W      = EPROD_W - E_FRAC;
    localparam int QP_W     = 2 * QUAT_W;
    localparam int ROT_W    = QP_W + 2;
    localparam int MPROD_W  = E_W + ROT_W;
    localparam int M_FRAC   = 20;
    localparam int M_W      = MPROD_W - M_FRAC;
    localparam int HALF_W   = M_W / 2;
    localparam int HH_W     = 2 * (M_W - HALF_W);
    localparam int HL_W     = (M_W - HALF_W) + HALF_W + 1;
    localparam int LL_W     = 2 * HALF_W;
    localparam int MID_W    = HL_W + 1;
    localparam int PROD_W   = 2 * M_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int C_FRAC   = 24;
    localparam int SH_W     = SUM_W - C_FRAC;
    localparam int COV_W    = 48;
    localparam int N_SCALE  = 3;
    localparam int N_QUAT   = 4;
    localparam int N_QP     = 9;
    localparam int N_ROT    = 9;
    localparam int N_COV    = 6;
    localparam int N_TERM   = 3;
    localparam int N_PROD   = N_COV * N_TERM;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(4096);
    localparam logic signed [ROT_W-1:0] ONE_Q28 = ROT_W'(64'sd268435456);

    // quaternion component slots
    localparam int QX = 0;
    localparam int QY = 1;
    localparam int QZ = 2;
    localparam int QW = 3;

    // row and column of each upper-triangular covariance entry
    localparam int COV_I [N_COV] = '{0, 0, 0, 1, 1, 2};
    localparam int COV_J [N_COV] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [N_SCALE-1:0][SCALE_W-1:0] scale;
        logic [N_QUAT-1:0][QUAT_W-1:0]   quat;
    } gcov_in_t;

    typedef struct packed {
        logic [N_SCALE-1:0][E_W-1:0]   e;
        logic [N_ROT-1:0][ROT_W-1:0]   r;
    } gcov_rot_t;

    typedef logic [N_ROT-1:0][M_W-1:0]     gcov_mat_t;
    typedef logic [N_PROD-1:0][PROD_W-1:0] gcov_prod_t;
    typedef logic [N_COV-1:0][COV_W-1:0]   gcov_cov_t;

endpackage
`default_nettype wire

// ===== rtl/gaussian_cov3d_from_scale_rot_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_cov3d_from_scale_rot_core
// 3d gaussian covariance from axis scales and a unit quaternion
//
//   channel   dir  width  contents
//   s_*       in   136    scales x,y,z (q8.16), quaternion x,y,z,w (q2.14)
//   m_*       out  288    cov xx,xy,xz,yy,yz,zz (q23.24, saturated)
//   cfg_wr_*  in   16     scale gain (q4.12)
//
// eight register stages, one transaction in and one out per cycle while the
// output is not stalled
// reset clears all stage valid bits and sets the scale gain to 1.0
// each stage holds while its successor is full and stalled; empty stages
// keep filling, so bubbles close up under a stalled output
// ----------------------------------------------------------------------------
module gaussian_cov3d_from_scale_rot_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // scale_x, scale_y, scale_z, quat_x, quat_y, quat_z, quat_w
    input  wire logic [135:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
    output logic [287:0]       m_tdata
);
    import gcov_pkg::*;

    logic [MOD_W-1:0] scale_mod_reg, scale_mod_next;
    gcov_in_t         in_data;
    gcov_rot_t        rot_data;
    gcov_mat_t        mat_data;
    gcov_prod_t       prod_data;
    gcov_cov_t        cov_data;
    logic             rot_valid, rot_ready;
    logic             mat_valid, mat_ready;
    logic             prod_valid, prod_ready;

    assign scale_mod_next = cfg_wr_en ? cfg_wr_data : scale_mod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_mod_reg <= MOD_RESET;
        end else begin
            scale_mod_reg <= scale_mod_next;
        end
    end

    always_comb begin
        for (int i = 0; i < N_SCALE; i++) begin
            in_data.scale[i] = s_tdata[i*SCALE_W +: SCALE_W];
        end
        for (int i = 0; i < N_QUAT; i++) begin
            in_data.quat[i] = s_tdata[N_SCALE*SCALE_W + i*QUAT_W +: QUAT_W];
        end
    end

    gcov_prep u_prep (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .scale_gain     (scale_mod_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_data        (in_data),
        .out_valid      (rot_valid),
        .out_ready      (rot_ready),
        .out_data       (rot_data)
    );

    gcov_mat u_mat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_data  (mat_data)
    );

    gcov_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_data   (mat_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    gcov_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (cov_data)
    );

    assign m_tdata = cov_data;

endmodule
`default_nettype wire

// ===== rtl/gcov_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcov_prep
// effective scales and rotation matrix from the quaternion, two stages
// ----------------------------------------------------------------------------
module gcov_prep (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [gcov_pkg::MOD_W-1:0] scale_gain,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire gcov_pkg::gcov_in_t      in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output gcov_pkg::gcov_rot_t          out_data
);
    import gcov_pkg::*;

    // quaternion product slots
    localparam int PXX = 0;
    localparam int PYY = 1;
    localparam int PZZ = 2;
    localparam int PXY = 3;
    localparam int PXZ = 4;
    localparam int PYZ = 5;
    localparam int PWX = 6;
    localparam int PWY = 7;
    localparam int PWZ = 8;

    logic                       v1_reg, v2_reg;
    logic                       ld1, ld2;
    logic [EPROD_W-1:0]         eprod_reg  [N_SCALE];
    logic [EPROD_W-1:0]         eprod_next [N_SCALE];
    logic signed [QP_W-1:0]     qp_reg     [N_QP];
    logic signed [QP_W-1:0]     qp_next    [N_QP];
    logic signed [QP_W-1:0]     qv         [N_QUAT];
    logic signed [ROT_W-1:0]    qe         [N_QP];
    logic [EPROD_W-1:0]         eround     [N_SCALE];
    gcov_rot_t                  rot_reg, rot_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 1: scale products and quaternion pair products
    always_comb begin
        for (int i = 0; i < N_QUAT; i++) begin
            qv[i] = QP_W'($signed(in_data.quat[i]));
        end
        for (int i = 0; i < N_SCALE; i++) begin
            eprod_next[i] = EPROD_W'(in_data.scale[i]) * EPROD_W'(scale_gain);
        end
        qp_next[PXX] = qv[QX] * qv[QX];
        qp_next[PYY] = qv[QY] * qv[QY];
        qp_next[PZZ] = qv[QZ] * qv[QZ];
        qp_next[PXY] = qv[QX] * qv[QY];
        qp_next[PXZ] = qv[QX] * qv[QZ];
        qp_next[PYZ] = qv[QY] * qv[QZ];
        qp_next[PWX] = qv[QW] * qv[QX];
        qp_next[PWY] = qv[QW] * qv[QY];
        qp_next[PWZ] = qv[QW] * qv[QZ];
    end

    // stage 2: round scales, assemble rotation in q28
    always_comb begin
        for (int i = 0; i < N_QP; i++) begin
            qe[i] = ROT_W'(qp_reg[i]);
        end
        for (int i = 0; i < N_SCALE; i++) begin
            eround[i]     = eprod_reg[i] + EPROD_W'(1 << (E_FRAC - 1));
            rot_next.e[i] = eround[i][EPROD_W-1:E_FRAC];
        end
        rot_next.r[0] = ONE_Q28 - ((qe[PYY] + qe[PZZ]) <<< 1);
        rot_next.r[1] = (qe[PXY] - qe[PWZ]) <<< 1;
        rot_next.r[2] = (qe[PXZ] + qe[PWY]) <<< 1;
        rot_next.r[3] = (qe[PXY] + qe[PWZ]) <<< 1;
        rot_next.r[4] = ONE_Q28 - ((qe[PXX] + qe[PZZ]) <<< 1);
        rot_next.r[5] = (qe[PYZ] - qe[PWX]) <<< 1;
        rot_next.r[6] = (qe[PXZ] - qe[PWY]) <<< 1;
        rot_next.r[7] = (qe[PYZ] + qe[PWX]) <<< 1;
        rot_next.r[8] = ONE_Q28 - ((qe[PXX] + qe[PYY]) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            eprod_reg <= eprod_next;
            qp_reg    <= qp_next;
        end
        if (ld2) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = rot_reg;

endmodule
`default_nettype wire

// ===== rtl/gcov_mat.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcov_mat
// scaled rotation matrix: multiply rows by scale, then round to q24
// ----------------------------------------------------------------------------
module gcov_mat (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gcov_pkg::gcov_rot_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gcov_pkg::gcov_mat_t      out_data
);
    import gcov_pkg::*;

    logic                       v1_reg, v2_reg;
    logic                       ld1, ld2;
    logic signed [MPROD_W-1:0]  prod_reg  [N_ROT];
    logic signed [MPROD_W-1:0]  prod_next [N_ROT];
    logic signed [MPROD_W-1:0]  ea        [N_SCALE];
    logic signed [MPROD_W-1:0]  rb        [N_ROT];
    logic signed [MPROD_W-1:0]  rnd       [N_ROT];
    gcov_mat_t                  mat_reg, mat_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 3: row scale times rotation entry
    always_comb begin
        for (int i = 0; i < N_SCALE; i++) begin
            ea[i] = MPROD_W'($signed({1'b0, in_data.e[i]}));
        end
        for (int k = 0; k < N_ROT; k++) begin
            rb[k] = MPROD_W'($signed(in_data.r[k]));
        end
        for (int row = 0; row < N_SCALE; row++) begin
            for (int col = 0; col < N_SCALE; col++) begin
                prod_next[row*3+col] = ea[row] * rb[row*3+col];
            end
        end
    end

    // stage 4: round half up to q24
    always_comb begin
        for (int k = 0; k < N_ROT; k++) begin
            rnd[k]      = prod_reg[k] + MPROD_W'(1 << (M_FRAC - 1));
            mat_next[k] = rnd[k][MPROD_W-1:M_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) prod_reg <= prod_next;
        if (ld2) mat_reg  <= mat_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = mat_reg;

endmodule
`default_nettype wire

// ===== rtl/gcov_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcov_mul
// wide column products m_ki * m_kj as split partial products, two stages
// ----------------------------------------------------------------------------
module gcov_mul (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gcov_pkg::gcov_mat_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gcov_pkg::gcov_prod_t     out_data
);
    import gcov_pkg::*;

    logic                       v1_reg, v2_reg;
    logic                       ld1, ld2;
    logic signed [HH_W-1:0]     hh_reg [N_PROD];
    logic signed [HL_W-1:0]     hl_reg [N_PROD];
    logic signed [HL_W-1:0]     lh_reg [N_PROD];
    logic [LL_W-1:0]            ll_reg [N_PROD];
    logic signed [HH_W-1:0]     hh_next [N_PROD];
    logic signed [HL_W-1:0]     hl_next [N_PROD];
    logic signed [HL_W-1:0]     lh_next [N_PROD];
    logic [LL_W-1:0]            ll_next [N_PROD];
    logic [M_W-1:0]             opa [N_PROD];
    logic [M_W-1:0]             opb [N_PROD];
    logic signed [HH_W-1:0]     ah  [N_PROD];
    logic signed [HH_W-1:0]     bh  [N_PROD];
    logic signed [HL_W-1:0]     ahx [N_PROD];
    logic signed [HL_W-1:0]     bhx [N_PROD];
    logic signed [HL_W-1:0]     alx [N_PROD];
    logic signed [HL_W-1:0]     blx [N_PROD];
    logic signed [MID_W-1:0]    mid [N_PROD];
    gcov_prod_t                 prod_reg, prod_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 5: split each operand into signed high and unsigned low halves and form the four partial products
    always_comb begin
        for (int c = 0; c < N_COV; c++) begin
            for (int k = 0; k < N_TERM; k++) begin
                opa[c*N_TERM+k] = in_data[k*3+COV_I[c]];
                opb[c*N_TERM+k] = in_data[k*3+COV_J[c]];
            end
        end
        for (int p = 0; p < N_PROD; p++) begin
            ah[p]  = HH_W'($signed(opa[p][M_W-1:HALF_W]));
            bh[p]  = HH_W'($signed(opb[p][M_W-1:HALF_W]));
            ahx[p] = HL_W'($signed(opa[p][M_W-1:HALF_W]));
            bhx[p] = HL_W'($signed(opb[p][M_W-1:HALF_W]));
            alx[p] = HL_W'($signed({1'b0, opa[p][HALF_W-1:0]}));
            blx[p] = HL_W'($signed({1'b0, opb[p][HALF_W-1:0]}));
            hh_next[p] = ah[p] * bh[p];
            hl_next[p] = ahx[p] * blx[p];
            lh_next[p] = alx[p] * bhx[p];
            ll_next[p] = LL_W'(opa[p][HALF_W-1:0]) * LL_W'(opb[p][HALF_W-1:0]);
        end
    end

    // stage 6: recombine partials into full products
    always_comb begin
        for (int p = 0; p < N_PROD; p++) begin
            mid[p] = MID_W'(hl_reg[p]) + MID_W'(lh_reg[p]);
            prod_next[p] = (PROD_W'(hh_reg[p]) <<< (2 * HALF_W))
                         + (PROD_W'(mid[p]) <<< HALF_W)
                         + PROD_W'(ll_reg[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (ld2) prod_reg <= prod_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = prod_reg;

endmodule
`default_nettype wire

// ===== rtl/gcov_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcov_acc
// sum of three column products, round to q24 and saturate to 48 bits
// ----------------------------------------------------------------------------
module gcov_acc (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gcov_pkg::gcov_prod_t in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output gcov_pkg::gcov_cov_t       out_data
);
    import gcov_pkg::*;

    localparam logic [COV_W-1:0] POS_SAT = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic [COV_W-1:0] NEG_SAT = {1'b1, {(COV_W-1){1'b0}}};

    logic                      v1_reg, v2_reg;
    logic                      ld1, ld2;
    logic signed [SUM_W-1:0]   sum_reg  [N_COV];
    logic signed [SUM_W-1:0]   sum_next [N_COV];
    logic [SH_W-1:0]           sh       [N_COV];
    gcov_cov_t                 cov_reg, cov_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 7: three-term sum plus rounding half
    always_comb begin
        for (int c = 0; c < N_COV; c++) begin
            sum_next[c] = SUM_W'($signed(in_data[c*N_TERM]))
                        + SUM_W'($signed(in_data[c*N_TERM+1]))
                        + SUM_W'($signed(in_data[c*N_TERM+2]))
                        + SUM_W'(1 << (C_FRAC - 1));
        end
    end

    // stage 8: shift down and clamp
    always_comb begin
        for (int c = 0; c < N_COV; c++) begin
            sh[c] = sum_reg[c][SUM_W-1:C_FRAC];
            if (&sh[c][SH_W-1:COV_W-1] || !(|sh[c][SH_W-1:COV_W-1])) begin
                cov_next[c] = sh[c][COV_W-1:0];
            end else if (sh[c][SH_W-1]) begin
                cov_next[c] = NEG_SAT;
            end else begin
                cov_next[c] = POS_SAT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) sum_reg <= sum_next;
        if (ld2) cov_reg <= cov_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = cov_reg;

endmodule
`default_nettype wire
